### sv/goal_queue_with_delete_by_id_defines.svh
// ----------------------------------------------------------------------------
// Goal queue assertion macros
// Shared assertion helpers for the goal queue RTL; define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef GOAL_QUEUE_WITH_DELETE_BY_ID_DEFINES_SVH
`define GOAL_QUEUE_WITH_DELETE_BY_ID_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define GQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be seen at a clock edge outside reset.
`define GQ_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define GQ_ASSERT(label, clk, rst, prop, msg)
`define GQ_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

### sv/gq_pkg.sv
// ----------------------------------------------------------------------------
// Goal queue package
// Command codes, status codes and the item types of the goal queue.
// ----------------------------------------------------------------------------
`default_nettype none

package gq_pkg;

   localparam int GOAL_COUNT_W = 5;

   typedef enum logic [3:0] {
      OP_PUSH         = 4'd0,
      OP_ADVANCE      = 4'd1,
      OP_KILL         = 4'd2,
      OP_CLEAR        = 4'd3,
      OP_MARK_REACHED = 4'd4,
      OP_PAUSE        = 4'd5,
      OP_RESUME       = 4'd6,
      OP_PEEK_CURRENT = 4'd7,
      OP_PEEK_NEXT    = 4'd8
   } gq_op_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      gq_op_type          op;
      logic signed [15:0] goal_id;
      logic [3:0]         goal_type;
      logic [31:0]        data_a;
      logic [31:0]        data_b;
      logic [31:0]        data_c;
   } gq_req_type;

   typedef struct packed {
      logic                    status;
      logic [GOAL_COUNT_W-1:0] goal_count;
      logic                    paused;
      logic                    entry_valid;
      logic [3:0]              entry_type;
      logic signed [15:0]      entry_id;
      logic                    entry_reached;
      logic [31:0]             entry_data_a;
      logic [31:0]             entry_data_b;
      logic [31:0]             entry_data_c;
   } gq_rsp_type;

   // One stored goal. The reached mark lives in a flag beside the store,
   // since only the head can ever carry it.
   typedef struct packed {
      logic [3:0]         goal_type;
      logic signed [15:0] goal_id;
      logic [31:0]        data_a;
      logic [31:0]        data_b;
      logic [31:0]        data_c;
   } gq_entry_type;

endpackage

`default_nettype wire

### sv/gq_ram.sv
// ----------------------------------------------------------------------------
// Goal queue RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/goal_queue_with_delete_by_id.sv
// ----------------------------------------------------------------------------
// Goal queue with delete by identifier
// Bounded ordered queue of motion goals with push, advance, kill by id,
// clear, mark reached, pause, resume and peek commands.
// ----------------------------------------------------------------------------
// A command item is taken when start is high and busy is low; busy then stays
// high until the command is finished. Exactly one result item follows each
// command and is shown on rsp_item for a single cycle with rsp_valid high;
// the receiver cannot stall it, so it must take the item in that cycle. The
// result carries the status, the goal count and pause flag after the
// command, and the head goal (the second goal for peek next). All commands
// but kill hold busy through the lookup and reply states, the result being
// registered in the reply state, and the next command can be taken in the
// cycle that the result is shown. A kill first walks the whole queue
// through the single read port of the goal store and one identifier
// comparator, one goal a cycle, and then passes through the same lookup and
// reply states. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "goal_queue_with_delete_by_id_defines.svh"

module goal_queue_with_delete_by_id
   import gq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire gq_req_type req_item,
   output logic            rsp_valid,
   output gq_rsp_type      rsp_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KILL,
      ST_LOOKUP,
      ST_REPLY
   } state_type;

   // Circular pointer step and head plus count, both wrapping at DEPTH.
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] c);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(p) + (CNT_W + 1)'(c);
      if (sum >= (CNT_W + 1)'(DEPTH)) begin
         sum = sum - (CNT_W + 1)'(DEPTH);
      end
      return PTR_W'(sum);
   endfunction

   state_type          state_ff,     state_in;
   logic [PTR_W-1:0]   head_ff,      head_in;
   logic [CNT_W-1:0]   count_ff,     count_in;
   logic               reached_ff,   reached_in;
   logic               pause_ff,     pause_in;
   logic               status_ff,    status_in;
   logic               peek_next_ff, peek_next_in;
   logic signed [15:0] kill_id_ff,   kill_id_in;
   logic [PTR_W-1:0]   rd_ptr_ff,    rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff,    wr_ptr_in;
   logic [CNT_W-1:0]   scan_ff,      scan_in;
   logic [CNT_W-1:0]   kept_ff,      kept_in;
   logic               pend_ff,      pend_in;
   logic               first_ff,     first_in;
   logic               slot_valid_ff,   slot_valid_in;
   logic               slot_reached_ff, slot_reached_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gq_rsp_type         rsp_ff,       rsp_in;

   logic               ram_wr_en;
   logic [PTR_W-1:0]   ram_wr_addr;
   gq_entry_type       ram_wr_data;
   logic [PTR_W-1:0]   ram_rd_addr;
   gq_entry_type       ram_rd_data;
   logic               scan_issue;

   gq_ram #(
      .WIDTH ($bits(gq_entry_type)),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer. Simple commands update the pointers at acceptance, then the
   // reported slot is read and the result is registered. A kill streams the
   // queue from the head: each entry read is compared against the id in the
   // cycle after its read and, if it survives, written back at the compacted position.
   always_comb begin
      state_in        = state_ff;
      head_in         = head_ff;
      count_in        = count_ff;
      reached_in      = reached_ff;
      pause_in        = pause_ff;
      status_in       = status_ff;
      peek_next_in    = peek_next_ff;
      kill_id_in      = kill_id_ff;
      rd_ptr_in       = rd_ptr_ff;
      wr_ptr_in       = wr_ptr_ff;
      scan_in         = scan_ff;
      kept_in         = kept_ff;
      pend_in         = pend_ff;
      first_in        = first_ff;
      slot_valid_in   = slot_valid_ff;
      slot_reached_in = slot_reached_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = ptr_add(head_ff, count_ff);
      ram_wr_data.goal_type = req_item.goal_type;
      ram_wr_data.goal_id   = req_item.goal_id;
      ram_wr_data.data_a    = req_item.data_a;
      ram_wr_data.data_b    = req_item.data_b;
      ram_wr_data.data_c    = req_item.data_c;
      ram_rd_addr = head_ff;
      scan_issue  = scan_ff < count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               status_in    = STATUS_OK;
               peek_next_in = (req_item.op == OP_PEEK_NEXT);
               state_in     = ST_LOOKUP;
               unique case (req_item.op)
                  OP_PUSH: begin
                     if (count_ff >= CNT_W'(DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           reached_in = 1'b0;
                        end
                     end
                  end
                  OP_ADVANCE: begin
                     if (count_ff != '0) begin
                        head_in    = ptr_inc(head_ff);
                        count_in   = count_ff - 1'b1;
                        reached_in = 1'b0;
                     end
                  end
                  OP_KILL: begin
                     kill_id_in = req_item.goal_id;
                     rd_ptr_in  = head_ff;
                     wr_ptr_in  = head_ff;
                     scan_in    = '0;
                     kept_in    = '0;
                     pend_in    = 1'b0;
                     first_in   = 1'b0;
                     state_in   = ST_KILL;
                  end
                  OP_CLEAR: begin
                     count_in   = '0;
                     reached_in = 1'b0;
                  end
                  OP_MARK_REACHED: begin
                     if (count_ff != '0) begin
                        reached_in = 1'b1;
                     end
                  end
                  OP_PAUSE:  pause_in = 1'b1;
                  OP_RESUME: pause_in = 1'b0;
                  default: begin
                  end
               endcase
            end
         end
         ST_KILL: begin
            ram_rd_addr = rd_ptr_ff;
            ram_wr_addr = wr_ptr_ff;
            ram_wr_data = ram_rd_data;
            pend_in     = scan_issue;
            first_in    = (scan_ff == '0);
            if (scan_issue) begin
               rd_ptr_in = ptr_inc(rd_ptr_ff);
               scan_in   = scan_ff + 1'b1;
            end
            if (pend_ff) begin
               if (ram_rd_data.goal_id != kill_id_ff) begin
                  ram_wr_en = 1'b1;
                  wr_ptr_in = ptr_inc(wr_ptr_ff);
                  kept_in   = kept_ff + 1'b1;
               end else if (first_ff) begin
                  // The head itself is removed, so the new head is unreached.
                  reached_in = 1'b0;
               end
            end
            if (!scan_issue && !pend_ff) begin
               count_in = kept_ff;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (peek_next_ff) begin
               ram_rd_addr     = ptr_inc(head_ff);
               slot_valid_in   = count_ff > CNT_W'(1);
               slot_reached_in = 1'b0;
            end else begin
               slot_valid_in   = count_ff != '0;
               slot_reached_in = reached_ff;
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            rsp_in.status     = status_ff;
            rsp_in.goal_count = GOAL_COUNT_W'(count_ff);
            rsp_in.paused     = pause_ff;
            if (slot_valid_ff) begin
               rsp_in.entry_valid   = 1'b1;
               rsp_in.entry_type    = ram_rd_data.goal_type;
               rsp_in.entry_id      = ram_rd_data.goal_id;
               rsp_in.entry_reached = slot_reached_ff;
               rsp_in.entry_data_a  = ram_rd_data.data_a;
               rsp_in.entry_data_b  = ram_rd_data.data_b;
               rsp_in.entry_data_c  = ram_rd_data.data_c;
            end else begin
               rsp_in.entry_valid   = 1'b0;
               rsp_in.entry_type    = '0;
               rsp_in.entry_id      = '0;
               rsp_in.entry_reached = 1'b0;
               rsp_in.entry_data_a  = '0;
               rsp_in.entry_data_b  = '0;
               rsp_in.entry_data_c  = '0;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         reached_ff   <= 1'b0;
         pause_ff     <= 1'b0;
         status_ff    <= STATUS_OK;
         peek_next_ff <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         scan_ff      <= '0;
         kept_ff      <= '0;
         pend_ff      <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         reached_ff   <= reached_in;
         pause_ff     <= pause_in;
         status_ff    <= status_in;
         peek_next_ff <= peek_next_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         scan_ff      <= scan_in;
         kept_ff      <= kept_in;
         pend_ff      <= pend_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kill_id_ff      <= kill_id_in;
      slot_valid_ff   <= slot_valid_in;
      slot_reached_ff <= slot_reached_in;
      rsp_ff          <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The queue never holds more goals than it has room for.
   `GQ_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(DEPTH), "goal count over depth")
   // An accepted command always makes the block busy in the next cycle.
   `GQ_ASSERT(a_busy_after_start, clock, reset, (start && !busy) |=> busy, "busy not raised")
   // A result strobe comes only out of the reply step.
   `GQ_ASSERT(a_rsp_from_reply, clock, reset, rsp_valid |-> $past(state_ff == ST_REPLY), "stray result")
   // Compaction never writes ahead of what it has read.
   `GQ_ASSERT_NEVER(a_kill_order, clock, reset, kept_ff > scan_ff, "kill write overtook read")

endmodule

`default_nettype wire

### test/goal_queue_with_delete_by_id_tb.sv
// ----------------------------------------------------------------------------
// Goal queue with delete by identifier testbench
// Drives command items through the start/busy handshake and predicts every
// result item with a cycle-free model of the ordered goal queue. Each result
// is compared field by field. A directed opening covers the empty queue, the
// field extremes, every command, unused command codes and kill by identifier.
// Random runs of pushes, drains, kills and peeks follow under three
// sender idling profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module goal_queue_with_delete_by_id_tb;
   import gq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 10;
   localparam int GOAL_DEPTH   = 16;
   // Generous bound on the whole run, well above the slowest correct run:
   // every item a kill over a full queue, sent after the longest idle gap of
   // the slowest idling profile.
   localparam int LIMIT_CYCLES = 400000;
   // A kill over a full queue is the longest command of the block.
   localparam int DRAIN_CYCLES = GOAL_DEPTH + 8;
   localparam int ITEMS_PER_PHASE = 518;

   // Command codes the block ignores; it then just reports the head.
   localparam logic [3:0] OP_CODE_UNUSED_FIRST = 4'd9;
   localparam logic [3:0] OP_CODE_UNUSED_LAST  = 4'd15;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   gq_req_type req_item = '0;
   logic       busy;
   logic       rsp_valid;
   gq_rsp_type rsp_item;

   // Commands waiting to be sent, and the result items they must produce.
   gq_req_type pending_commands[$];
   gq_rsp_type expected_responses[$];

   // Percentage of cycles in which the sender holds start low.
   int send_idle_pct = 6;
   int fail_count = 0;
   int cycle_count = 0;

   // Predictor state: the goals in queue order (head at index 0), the
   // reached mark of each, the number held and the pause flag.
   gq_entry_type model_goals[GOAL_DEPTH];
   logic         model_reached[GOAL_DEPTH];
   int           model_held = 0;
   logic         model_paused = 1'b0;

   goal_queue_with_delete_by_id #(
      .DEPTH(GOAL_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Apply one command to the predicted queue and return the result item it
   // must produce. The reported goal is the head after the command, or the
   // second goal for a peek next; a missing goal reports all zeros.
   function automatic gq_rsp_type predict_goal_response(input gq_req_type cmd);
      gq_rsp_type rsp;
      int         slot;
      int         wr;
      rsp = '0;
      rsp.status = STATUS_OK;
      slot = 0;
      case (cmd.op)
         OP_PUSH: begin
            if (model_held >= GOAL_DEPTH) begin
               rsp.status = STATUS_FULL;
            end else begin
               model_goals[model_held].goal_type = cmd.goal_type;
               model_goals[model_held].goal_id   = cmd.goal_id;
               model_goals[model_held].data_a    = cmd.data_a;
               model_goals[model_held].data_b    = cmd.data_b;
               model_goals[model_held].data_c    = cmd.data_c;
               model_reached[model_held] = 1'b0;
               model_held++;
            end
         end
         OP_ADVANCE: begin
            if (model_held > 0) begin
               for (int k = 1; k < model_held; k++) begin
                  model_goals[k - 1]   = model_goals[k];
                  model_reached[k - 1] = model_reached[k];
               end
               model_held--;
            end
         end
         OP_KILL: begin
            // Compact the survivors toward the head, keeping their order.
            wr = 0;
            for (int rd = 0; rd < model_held; rd++) begin
               if (model_goals[rd].goal_id != cmd.goal_id) begin
                  model_goals[wr]   = model_goals[rd];
                  model_reached[wr] = model_reached[rd];
                  wr++;
               end
            end
            model_held = wr;
         end
         OP_CLEAR: model_held = 0;
         OP_MARK_REACHED: begin
            if (model_held > 0) begin
               model_reached[0] = 1'b1;
            end
         end
         OP_PAUSE: model_paused = 1'b1;
         OP_RESUME: model_paused = 1'b0;
         OP_PEEK_NEXT: slot = 1;
         default: ;
      endcase
      rsp.goal_count = model_held[GOAL_COUNT_W-1:0];
      rsp.paused = model_paused;
      if (slot < model_held) begin
         rsp.entry_valid   = 1'b1;
         rsp.entry_type    = model_goals[slot].goal_type;
         rsp.entry_id      = model_goals[slot].goal_id;
         rsp.entry_reached = model_reached[slot];
         rsp.entry_data_a  = model_goals[slot].data_a;
         rsp.entry_data_b  = model_goals[slot].data_b;
         rsp.entry_data_c  = model_goals[slot].data_c;
      end
      return rsp;
   endfunction

   task automatic check_response(input gq_rsp_type exp, input gq_rsp_type act);
      if (act.status !== exp.status) begin
         $error("status: expected %0d, actual %0d", exp.status, act.status);
         fail_count++;
      end
      if (act.goal_count !== exp.goal_count) begin
         $error("goal_count: expected %0d, actual %0d", exp.goal_count, act.goal_count);
         fail_count++;
      end
      if (act.paused !== exp.paused) begin
         $error("paused: expected %0d, actual %0d", exp.paused, act.paused);
         fail_count++;
      end
      if (act.entry_valid !== exp.entry_valid) begin
         $error("entry_valid: expected %0d, actual %0d", exp.entry_valid, act.entry_valid);
         fail_count++;
      end
      if (act.entry_type !== exp.entry_type) begin
         $error("entry_type: expected %0d, actual %0d", exp.entry_type, act.entry_type);
         fail_count++;
      end
      if (act.entry_id !== exp.entry_id) begin
         $error("entry_id: expected %0d, actual %0d", exp.entry_id, act.entry_id);
         fail_count++;
      end
      if (act.entry_reached !== exp.entry_reached) begin
         $error("entry_reached: expected %0d, actual %0d", exp.entry_reached,
                act.entry_reached);
         fail_count++;
      end
      if (act.entry_data_a !== exp.entry_data_a) begin
         $error("entry_data_a: expected %h, actual %h", exp.entry_data_a, act.entry_data_a);
         fail_count++;
      end
      if (act.entry_data_b !== exp.entry_data_b) begin
         $error("entry_data_b: expected %h, actual %h", exp.entry_data_b, act.entry_data_b);
         fail_count++;
      end
      if (act.entry_data_c !== exp.entry_data_c) begin
         $error("entry_data_c: expected %h, actual %h", exp.entry_data_c, act.entry_data_c);
         fail_count++;
      end
   endtask

   task automatic queue_command(input gq_op_type op, input int id, input int gtype,
                                input logic [31:0] word_a, input logic [31:0] word_b,
                                input logic [31:0] word_c);
      gq_req_type cmd;
      cmd.op        = op;
      cmd.goal_id   = id[15:0];
      cmd.goal_type = gtype[3:0];
      cmd.data_a    = word_a;
      cmd.data_b    = word_b;
      cmd.data_c    = word_c;
      pending_commands.push_back(cmd);
   endtask

   // Block until the driver has handed over every pending item and every
   // result item has come back.
   task automatic wait_for_drain();
      while (pending_commands.size() != 0 || expected_responses.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // One random phase. Commands come in runs with a push bias drawn per
   // run: push-heavy runs fill the queue up to the full refusal, the others
   // drain it through advances, kills and clears. Identifiers come mostly
   // from a small pool so that kills hit one or several goals, and now and
   // then from the full 16-bit range.
   task automatic run_random_phase(input int idle_pct, input int item_total);
      gq_req_type cmd;
      int         queued;
      int         push_weight;
      int         run_length;
      int         pick;
      send_idle_pct = idle_pct;
      queued = 0;
      while (queued < item_total) begin
         case ($urandom_range(0, 2))
            0: push_weight = 85;
            1: push_weight = 50;
            default: push_weight = 20;
         endcase
         run_length = $urandom_range(10, 40);
         for (int i = 0; i < run_length && queued < item_total; i++) begin
            if ($urandom_range(0, 99) < 75) begin
               cmd.goal_id = 16'($signed($urandom_range(0, 5)) - 2);
            end else begin
               cmd.goal_id = 16'($urandom_range(0, 16'hFFFF));
            end
            cmd.goal_type = 4'($urandom_range(0, 15));
            cmd.data_a = $urandom();
            cmd.data_b = $urandom();
            cmd.data_c = $urandom();
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < push_weight) begin
               cmd.op = OP_PUSH;
            end else if (pick < 25) begin
               cmd.op = OP_ADVANCE;
            end else if (pick < 42) begin
               cmd.op = OP_KILL;
            end else if (pick < 46) begin
               cmd.op = OP_CLEAR;
            end else if (pick < 58) begin
               cmd.op = OP_MARK_REACHED;
            end else if (pick < 66) begin
               cmd.op = OP_PAUSE;
            end else if (pick < 74) begin
               cmd.op = OP_RESUME;
            end else if (pick < 84) begin
               cmd.op = OP_PEEK_CURRENT;
            end else if (pick < 94) begin
               cmd.op = OP_PEEK_NEXT;
            end else begin
               cmd.op = gq_op_type'(4'($urandom_range(OP_CODE_UNUSED_FIRST,
                                                      OP_CODE_UNUSED_LAST)));
            end
            pending_commands.push_back(cmd);
            queued++;
         end
      end
      wait_for_drain();
   endtask

   // Driver. An item counts as accepted at an edge where start was high and
   // busy low; its prediction is made there, before the block can answer.
   // Start is then raised again for the next pending item unless the sender
   // decides to idle this cycle. Only one assignment to start per edge.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_responses.push_back(predict_goal_response(req_item));
            void'(pending_commands.pop_front());
         end
         if (!start || !busy) begin
            if (pending_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               start <= 1'b1;
               req_item <= pending_commands[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor. The block cannot be held off, so every strobed result item is
   // taken at the edge that ends its cycle and checked against the oldest
   // prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_responses.size() == 0) begin
            $error("result item with no command waiting for it");
            fail_count++;
         end else begin
            check_response(expected_responses.pop_front(), rsp_item);
         end
      end
   end

   // Watchdog against a hung handshake or a lost result item.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("goal_queue_with_delete_by_id test failed");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed opening with the light idling profile. Peeks, advance, mark
      // reached and kill on an empty queue first, so that nothing is reported and nothing changes.
      send_idle_pct = 6;
      queue_command(OP_PEEK_CURRENT, 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_PEEK_NEXT, 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_ADVANCE, 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_MARK_REACHED, 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_KILL, 0, 0, 32'h0, 32'h0, 32'h0);
      // Field extremes: lowest and highest identifier, type and data words.
      queue_command(OP_PUSH, -32768, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_PUSH, 32767, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_command(OP_PEEK_NEXT, 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_MARK_REACHED, 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_PEEK_CURRENT, 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_PAUSE, 0, 0, 32'h0, 32'h0, 32'h0);
      // Unused command codes leave the queue alone and report the head.
      queue_command(gq_op_type'(OP_CODE_UNUSED_FIRST), 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(gq_op_type'(OP_CODE_UNUSED_LAST), 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_PUSH, 5, 3, $urandom(), $urandom(), $urandom());
      queue_command(OP_PUSH, -32768, 7, $urandom(), $urandom(), $urandom());
      // The kill removes the reached head and the last goal, which share an
      // identifier, and the new head shows no reached mark.
      queue_command(OP_KILL, -32768, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_PEEK_CURRENT, 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_ADVANCE, 0, 0, 32'h0, 32'h0, 32'h0);
      // A kill that matches nothing changes nothing.
      queue_command(OP_KILL, 99, 0, 32'h0, 32'h0, 32'h0);
      // Clear keeps the pause flag; resume then drops it.
      queue_command(OP_CLEAR, 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_RESUME, 0, 0, 32'h0, 32'h0, 32'h0);
      queue_command(OP_PEEK_CURRENT, 0, 0, 32'h0, 32'h0, 32'h0);
      wait_for_drain();

      // Random part: light sender idling, heavy sender idling, then none.
      run_random_phase(6, ITEMS_PER_PHASE);
      run_random_phase(67, ITEMS_PER_PHASE);
      run_random_phase(0, ITEMS_PER_PHASE);

      // Let any late or stray result item show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("goal_queue_with_delete_by_id test passed");
      end else begin
         $display("goal_queue_with_delete_by_id test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
+incdir+sv
sv/gq_pkg.sv
sv/gq_ram.sv
sv/goal_queue_with_delete_by_id.sv
test/goal_queue_with_delete_by_id_tb.sv
